### rtl/wpcs_pkg.sv
// Shared types and constants for the waveform peak column span block.
package wpcs_pkg;

  localparam int SampleW = 16;
  localparam int DimW    = 13;
  localparam int NumW    = 24;
  localparam int BoundW  = 37;
  localparam int RowW    = 12;
  localparam int BurstW  = 6;
  localparam int ProdW   = DimW + SampleW + 1;

  localparam logic [DimW-1:0] DimMax       = 13'd4096;
  localparam logic [DimW-1:0] ResetColumns = 13'd256;
  localparam logic [DimW-1:0] ResetHeight  = 13'd256;
  localparam logic [NumW-1:0] ResetSamples = 24'd65536;
  localparam logic [BurstW-1:0] BurstLast  = 6'd63;

  typedef struct packed {
    logic load;
    logic calc_top;
    logic calc_bot;
    logic advance;
    logic rearm;
  } cmd_t;

  typedef struct packed {
    logic due;
    logic last;
    logic final_col;
  } status_t;

endpackage

### rtl/waveform_peak_column_spans_top.sv
// Top level of the waveform peak column span block with its register port.
//
// Usage: audio samples enter as beats on the input channel (in_valid,
// in_ready, sample). Each beat updates the running min and max and may
// close zero to 64 columns; every closed column leaves as one beat on the
// output channel (out_valid, out_ready, column, row_top, row_bottom,
// last_in_run, last_column). last_in_run marks the final span of a sample.
// Sequence: a sample that closes no column passes only the accept and
// the bound compare. Each span adds the single row multiplier mapping
// the max and then the min, and its wait in the output register. Input
// is held off until every span of the current sample is delivered; a
// stalled receiver simply holds the output beat and the sequencer.
// Reset loads 256 columns, 256 rows and 65536 samples per image and
// arms for a new image; any register write rearms the same way in the
// cycle after the write, with input held off for that cycle. The user
// must write registers only while the block is idle; the block does
// not enforce it. No clearing pass is needed.
module waveform_peak_column_spans_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [wpcs_pkg::SampleW-1:0] sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [wpcs_pkg::RowW-1:0]          column,
  output logic [wpcs_pkg::RowW-1:0]          row_top,
  output logic [wpcs_pkg::RowW-1:0]          row_bottom,
  output logic                               last_in_run,
  output logic                               last_column,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [3:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import wpcs_pkg::*;

  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_SAMPLES = 2'd2;

  logic [DimW-1:0] num_columns;
  logic [DimW-1:0] image_height;
  logic [NumW-1:0] sample_count;
  logic [DimW-1:0] width;
  logic [DimW-1:0] height;
  logic [1:0]      reg_idx;
  logic            wr_beat;
  logic            cfg_wr;
  cmd_t            cmd;
  status_t         status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_beat = psel && penable && pwrite && pready;
  assign cfg_wr  = wr_beat && ((reg_idx == REG_COLUMNS) || (reg_idx == REG_HEIGHT) ||
                               (reg_idx == REG_SAMPLES));

  always_ff @(posedge clk) begin
    if (rst) begin
      num_columns  <= ResetColumns;
      image_height <= ResetHeight;
      sample_count <= ResetSamples;
    end else if (wr_beat) begin
      case (reg_idx)
        REG_COLUMNS: num_columns  <= pwdata[DimW-1:0];
        REG_HEIGHT:  image_height <= pwdata[DimW-1:0];
        REG_SAMPLES: sample_count <= pwdata[NumW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COLUMNS: prdata = 32'(num_columns);
      REG_HEIGHT:  prdata = 32'(image_height);
      REG_SAMPLES: prdata = 32'(sample_count);
      default:     prdata = '0;
    endcase
  end

  assign width  = (num_columns == '0) ? DimW'(1) :
                  ((num_columns > DimMax) ? DimMax : num_columns);
  assign height = (image_height == '0) ? DimW'(1) :
                  ((image_height > DimMax) ? DimMax : image_height);

  wpcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .cfg_wr    (cfg_wr),
    .status    (status),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  wpcs_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sample      (sample),
    .width       (width),
    .height      (height),
    .samples     (sample_count),
    .status      (status),
    .column      (column),
    .row_top     (row_top),
    .row_bottom  (row_bottom),
    .last_in_run (last_in_run),
    .last_column (last_column)
  );

endmodule

### rtl/wpcs_ctrl.sv
// Sequencer for sample intake, column close-out and span delivery.
module wpcs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_ready,
  input  logic              cfg_wr,
  input  wpcs_pkg::status_t status,
  output logic              in_ready,
  output logic              out_valid,
  output wpcs_pkg::cmd_t    cmd
);
  import wpcs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_TOP   = 3'd2;
  localparam logic [2:0] S_BOT   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       rearm_pend;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && !rearm_pend) state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = status.due ? S_TOP : S_IDLE;
      end
      S_TOP: begin
        state_next = S_BOT;
      end
      S_BOT: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready) state_next = status.last ? S_IDLE : S_TOP;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rearm_pend <= 1'b0;
    end else begin
      state      <= state_next;
      rearm_pend <= cfg_wr;
    end
  end

  // rearm in the cycle after the write so the new register value is used
  assign in_ready      = (state == S_IDLE) && !rearm_pend;
  assign out_valid     = (state == S_EMIT);
  assign cmd.load      = (state == S_IDLE) && !rearm_pend && in_valid;
  assign cmd.calc_top  = (state == S_TOP);
  assign cmd.calc_bot  = (state == S_BOT);
  assign cmd.advance   = (state == S_EMIT) && out_ready;
  assign cmd.rearm     = rearm_pend;

`ifndef NO_ASSERTIONS
  a_load_checks: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_CHECK)
    else $error("accepted beat not followed by bound check");
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    cmd.advance && !status.last |=> state == S_TOP)
    else $error("burst stopped before last span");
  a_final_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status.final_col |-> status.last)
    else $error("final column not flagged last in run");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while span pending");
`endif

endmodule

### rtl/wpcs_datapath.sv
// Running extremes, column bounds and row mapping for the span block.
module wpcs_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  wpcs_pkg::cmd_t                     cmd,
  input  logic signed [wpcs_pkg::SampleW-1:0] sample,
  input  logic [wpcs_pkg::DimW-1:0]          width,
  input  logic [wpcs_pkg::DimW-1:0]          height,
  input  logic [wpcs_pkg::NumW-1:0]          samples,
  output wpcs_pkg::status_t                  status,
  output logic [wpcs_pkg::RowW-1:0]          column,
  output logic [wpcs_pkg::RowW-1:0]          row_top,
  output logic [wpcs_pkg::RowW-1:0]          row_bottom,
  output logic                               last_in_run,
  output logic                               last_column
);
  import wpcs_pkg::*;

  logic signed [SampleW-1:0] prev_sample;
  logic signed [SampleW-1:0] running_min;
  logic signed [SampleW-1:0] running_max;
  logic [DimW-1:0]           column_index;
  logic [BoundW-1:0]         column_bound;
  logic [BoundW-1:0]         count_bound;
  logic [BoundW-1:0]         bound_next;
  logic                      first_pending;
  logic [BurstW-1:0]         burst;
  logic                      last_r;
  logic                      final_r;

  logic signed [SampleW-1:0] min_next;
  logic signed [SampleW-1:0] max_next;
  logic signed [SampleW-1:0] mul_src;
  logic [SampleW:0]          level_gap;
  logic [ProdW-1:0]          prod;
  logic [DimW:0]             row_raw;
  logic [DimW-1:0]           row_clamped;
  logic                      is_final;

  always_comb begin
    min_next = first_pending ? sample : ((sample < running_min) ? sample : running_min);
    max_next = first_pending ? sample : ((sample > running_max) ? sample : running_max);
  end

  assign mul_src   = cmd.calc_top ? running_max : running_min;
  assign level_gap = {2'b01, {(SampleW-1){1'b0}}} - {mul_src[SampleW-1], mul_src};
  assign prod      = ProdW'(height) * ProdW'(level_gap);
  assign row_raw = prod[ProdW-1:SampleW];
  assign row_clamped = (row_raw >= {1'b0, height}) ? (height - 1'b1) : row_raw[DimW-1:0];
  assign is_final = (column_index == (width - 1'b1));

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample   <= '0;
      running_min   <= '0;
      running_max   <= '0;
      column_index  <= '0;
      column_bound  <= BoundW'(ResetSamples);
      count_bound   <= BoundW'(ResetColumns);
      first_pending <= 1'b1;
      burst         <= '0;
    end else if (cmd.rearm) begin
      prev_sample   <= '0;
      running_min   <= '0;
      running_max   <= '0;
      column_index  <= '0;
      column_bound  <= BoundW'(samples);
      count_bound   <= BoundW'(width);
      first_pending <= 1'b1;
      burst         <= '0;
    end else if (cmd.load) begin
      prev_sample   <= sample;
      running_min   <= min_next;
      running_max   <= max_next;
      count_bound   <= count_bound + BoundW'(width);
      first_pending <= 1'b0;
      burst         <= '0;
    end else if (cmd.advance) begin
      running_min <= prev_sample;
      running_max <= prev_sample;
      if (final_r) begin
        prev_sample   <= '0;
        running_min   <= '0;
        running_max   <= '0;
        column_index  <= '0;
        column_bound  <= BoundW'(samples);
        count_bound   <= BoundW'(width);
        first_pending <= 1'b1;
      end else begin
        column_index <= column_index + 1'b1;
        column_bound <= bound_next;
        burst        <= burst + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_top) begin
      row_top    <= row_clamped[RowW-1:0];
      bound_next <= column_bound + BoundW'(samples);
    end
    if (cmd.calc_bot) begin
      row_bottom <= row_clamped[RowW-1:0];
      final_r    <= is_final;
      last_r     <= is_final || (burst == BurstLast) || !(bound_next < count_bound);
    end
  end

  assign status.due       = (column_bound < count_bound);
  assign status.last      = last_r;
  assign status.final_col = final_r;

  assign column      = column_index[RowW-1:0];
  assign last_in_run = last_r;
  assign last_column = final_r;

endmodule
